// ===== hdl/bpfa_pkg.sv =====
package bpfa_pkg;

    localparam int DEF_MAX_FRAMES = 32768;
    localparam int PAGE_BYTES     = 4096;   // power of two
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int CFG_TOTAL_RST  = 32768;

    localparam int CFG_W  = 16;
    localparam int OP_W   = 3;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 32;
    localparam int PA_W   = 27;
    localparam int BYTES_W = 28;

    localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE_PAGE = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK_USED = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd3;
    localparam logic [OP_W-1:0] OP_MARK_ALL  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [PA_W-1:0]    page_address;
        logic [BYTES_W-1:0] free_bytes;
        logic [BYTES_W-1:0] total_bytes;
    } out_item_t;

    typedef enum logic [1:0] {
        MODE_ALLOC,
        MODE_SET,
        MODE_CLEAR
    } word_mode_t;

    // bit range [lo_bit, hi_bit] of the current bitmap word
    typedef struct packed {
        word_mode_t mode;
        logic [4:0] lo_bit;
        logic [4:0] hi_bit;
    } word_ctrl_t;

    typedef struct packed {
        logic [31:0] new_word;
        logic        hit;
        logic [4:0]  bit_idx;
        logic [5:0]  delta;
    } word_res_t;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++) begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    // index of the single set bit of a one-hot word
    function automatic logic [4:0] onehot_index(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/bitmap_page_frame_allocator.sv =====
// Bitmap page-frame allocator: one used bit per frame in a 32-bit-wide bitmap memory, worked one
// word at a time by a single read-modify-write unit. An allocate reads (S_RD) and modifies (S_MOD)
// each bitmap word scanned up to the first word with a free frame, free and region marks each word
// touched, each after S_SETUP and followed by S_FIN and S_DONE; mark-all rewrites every word,
// one per cycle (1024 words by default). The same sweep runs after reset and after every
// write of total_frames; no item is taken during it. Input stalls while an item is in work.
module bitmap_page_frame_allocator #(
    parameter int MAX_FRAMES = bpfa_pkg::DEF_MAX_FRAMES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bpfa_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bpfa_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bpfa_pkg::out_item_t        out_data
);
    import bpfa_pkg::*;

    localparam int MAP_WORDS = (MAX_FRAMES + 31) / 32;
    localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FW = $clog2(MAX_FRAMES + 1);
    localparam int AW = ADDR_W - PAGE_SHIFT;
    localparam int EW = (AW + 2 > FW) ? AW + 2 : FW;
    localparam int TOT_RESET = (CFG_TOTAL_RST > MAX_FRAMES) ? MAX_FRAMES : CFG_TOTAL_RST;
    localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

    typedef enum logic [6:0] {
        S_FILL  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_RD    = 7'b0001000,
        S_MOD   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [WW-1:0] word_reg, word_next;
    logic [WW-1:0] first_word_reg, first_word_next;
    logic [WW-1:0] last_word_reg, last_word_next;
    logic [4:0]    lo_bit_reg, lo_bit_next;
    logic [4:0]    hi_bit_reg, hi_bit_next;
    word_mode_t    mode_reg, mode_next;
    in_item_t      req_reg, req_next;
    logic [FW-1:0] used_reg, used_next;
    logic [FW-1:0] tot_reg, tot_next;
    logic [5:0]    delta_reg, delta_next;
    logic          pend_reg, pend_next;
    logic          status_reg, status_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    logic [31:0]   map_mem [MAP_WORDS];
    logic [31:0]   rd_word_reg;
    logic          mem_we;
    logic [31:0]   mem_wdata;

    word_ctrl_t    unit_ctrl;
    word_res_t     unit_res;

    logic          cfg_fire;
    logic [31:0]   cfg_ext;
    logic [EW-1:0] first_ext;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] end_ext;
    logic [EW-1:0] tot_ext;
    logic [EW-1:0] hi_clip;
    logic [EW-1:0] hi_m1;
    logic          round_up;
    logic          empty;
    logic [FW-1:0] tot_m1;
    logic [FW-1:0] free_frames;
    logic [63:0]   free_full;
    logic [63:0]   total_full;
    logic [63:0]   page_full;

    bpfa_word_unit u_word_unit (
        .ctrl     (unit_ctrl),
        .old_word (rd_word_reg),
        .res      (unit_res)
    );

    assign cfg_ready = (state_reg == S_IDLE) || ((state_reg == S_FILL) && !pend_reg);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_ext   = 32'(cfg_data);
    // a pending register write wins over a new item
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign mem_we    = (state_reg == S_FILL) || (state_reg == S_MOD);
    assign mem_wdata = (state_reg == S_FILL) ? 32'hFFFF_FFFF : unit_res.new_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[word_reg] <= mem_wdata;
        end
        if (state_reg == S_RD)
        begin
            rd_word_reg <= map_mem[word_reg];
        end
    end

    // region bounds in frames, clipped at the managed total
    always_comb
    begin
        first_ext = EW'(req_reg.address[ADDR_W-1:PAGE_SHIFT]);
        round_up  = (req_reg.operation == OP_MARK_USED) && (|req_reg.length[PAGE_SHIFT-1:0]);
        if (req_reg.operation == OP_FREE_PAGE)
        begin
            cnt_ext = EW'(1);
        end
        else
        begin
            cnt_ext = EW'(req_reg.length[LEN_W-1:PAGE_SHIFT]);
        end
        end_ext = first_ext + cnt_ext + EW'(round_up);
        tot_ext = EW'(tot_reg);
        hi_clip = (end_ext > tot_ext) ? tot_ext : end_ext;
        empty   = (first_ext >= hi_clip);
        hi_m1   = hi_clip - EW'(1);
        tot_m1  = tot_reg - FW'(1);
    end

    always_comb
    begin
        unit_ctrl.mode   = mode_reg;
        unit_ctrl.lo_bit = (word_reg == first_word_reg) ? lo_bit_reg : 5'd0;
        unit_ctrl.hi_bit = (word_reg == last_word_reg) ? hi_bit_reg : 5'd31;
    end

    always_comb
    begin
        free_frames = tot_reg - used_reg;
        free_full   = 64'(free_frames) << PAGE_SHIFT;
        total_full  = 64'(tot_reg) << PAGE_SHIFT;
        page_full   = 64'(frame_reg) << PAGE_SHIFT;
    end

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        first_word_next = first_word_reg;
        last_word_next  = last_word_reg;
        lo_bit_next     = lo_bit_reg;
        hi_bit_next     = hi_bit_reg;
        mode_next       = mode_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        tot_next        = tot_reg;
        delta_next      = delta_reg;
        pend_next       = pend_reg;
        status_next     = status_reg;
        frame_next      = frame_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            S_FILL:
            begin
                word_next = word_reg + WW'(1);
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next    = in_data;
                    status_next = 1'b0;
                    frame_next  = '0;
                    delta_next  = '0;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                unique case (req_reg.operation)
                    OP_ALLOC:
                    begin
                        mode_next = MODE_ALLOC;
                        if (tot_reg == '0)
                        begin
                            status_next = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            word_next       = '0;
                            first_word_next = '0;
                            lo_bit_next     = '0;
                            last_word_next  = tot_m1[5 +: WW];
                            hi_bit_next     = tot_m1[4:0];
                            state_next      = S_RD;
                        end
                    end
                    OP_FREE_PAGE, OP_MARK_USED, OP_MARK_FREE:
                    begin
                        mode_next = (req_reg.operation == OP_MARK_USED) ? MODE_SET : MODE_CLEAR;
                        if (empty)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            word_next       = first_ext[5 +: WW];
                            first_word_next = first_ext[5 +: WW];
                            lo_bit_next     = first_ext[4:0];
                            last_word_next  = hi_m1[5 +: WW];
                            hi_bit_next     = hi_m1[4:0];
                            state_next      = S_RD;
                        end
                    end
                    OP_MARK_ALL:
                    begin
                        used_next  = tot_reg;
                        word_next  = '0;
                        pend_next  = 1'b1;
                        state_next = S_FILL;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RD, S_FIN:
            begin
                // fold in the flip count of the word written last
                if (mode_reg == MODE_CLEAR)
                begin
                    used_next = used_reg - FW'(delta_reg);
                end
                else
                begin
                    used_next = used_reg + FW'(delta_reg);
                end
                delta_next = '0;
                state_next = (state_reg == S_RD) ? S_MOD : S_DONE;
            end
            S_MOD:
            begin
                delta_next = unit_res.delta;
                if ((mode_reg == MODE_ALLOC) && unit_res.hit)
                begin
                    frame_next = FW'({word_reg, unit_res.bit_idx});
                    state_next = S_FIN;
                end
                else if (word_reg == last_word_reg)
                begin
                    status_next = (mode_reg == MODE_ALLOC);
                    state_next  = S_FIN;
                end
                else
                begin
                    word_next  = word_reg + WW'(1);
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.page_address = page_full[PA_W-1:0];
                    out_data_next.free_bytes   = free_full[BYTES_W-1:0];
                    out_data_next.total_bytes  = total_full[BYTES_W-1:0];
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write reinitializes the whole map
        if (cfg_fire)
        begin
            tot_next   = (cfg_ext > 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(cfg_ext);
            used_next  = tot_next;
            word_next  = '0;
            pend_next  = 1'b0;
            state_next = S_FILL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            word_reg      <= '0;
            used_reg      <= FW'(TOT_RESET);
            tot_reg       <= FW'(TOT_RESET);
            delta_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            used_reg      <= used_next;
            tot_reg       <= tot_next;
            delta_reg     <= delta_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_word_reg <= first_word_next;
        last_word_reg  <= last_word_next;
        lo_bit_reg     <= lo_bit_next;
        hi_bit_reg     <= hi_bit_next;
        mode_reg       <= mode_next;
        req_reg        <= req_next;
        status_reg     <= status_next;
        frame_reg      <= frame_next;
        out_data_reg   <= out_data_next;
    end

    a_used_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= tot_reg)
        else $error("used frame count exceeds managed total");

    a_oom_zero_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.page_address == '0)
        else $error("out-of-memory result carries a page address");

    a_cfg_restarts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> (state_reg == S_FILL) && (word_reg == '0))
        else $error("register write did not restart the map sweep");

    a_alloc_single_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) && (mode_reg == MODE_ALLOC) && unit_res.hit
        |-> unit_res.delta == 6'd1)
        else $error("allocation flipped other than one bit");

endmodule

// ===== hdl/bpfa_word_unit.sv =====
module bpfa_word_unit (
    input  bpfa_pkg::word_ctrl_t ctrl,
    input  logic [31:0]          old_word,
    output bpfa_pkg::word_res_t  res
);
    import bpfa_pkg::*;

    logic [31:0] range_mask;
    logic [31:0] cand;
    logic [31:0] mask;
    logic [31:0] flips;

    always_comb
    begin
        range_mask = ({32{1'b1}} << ctrl.lo_bit) & ({32{1'b1}} >> (5'd31 - ctrl.hi_bit));
        cand       = ~old_word & range_mask;
        // allocation picks the lowest free bit only
        if (ctrl.mode == MODE_ALLOC)
        begin
            mask = cand & (~cand + 32'd1);
        end
        else
        begin
            mask = range_mask;
        end
        if (ctrl.mode == MODE_CLEAR)
        begin
            res.new_word = old_word & ~mask;
            flips        = old_word & mask;
        end
        else
        begin
            res.new_word = old_word | mask;
            flips        = ~old_word & mask;
        end
        res.hit     = |cand;
        res.bit_idx = onehot_index(mask);
        res.delta   = popcount32(flips);
    end

endmodule
